/* src/grid_mesh_index_generator_top_assert.svh */
// Assertion macros used by the grid mesh index generator checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef GRID_MESH_INDEX_GENERATOR_TOP_ASSERT_SVH
`define GRID_MESH_INDEX_GENERATOR_TOP_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define GMIG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define GMIG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

/* src/gmig_pkg.sv */
// Shared types and constants of the grid mesh index generator.
// No dependencies.
`timescale 1ns / 1ps

package gmig_pkg;

  localparam int unsigned DefMaxColumns = 4096;
  localparam int unsigned DefMaxRows    = 4096;

  localparam int unsigned DimWidth   = 13;
  localparam int unsigned IndexWidth = 32;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [IndexWidth-1:0] RestartWord = 32'hffff_ffff;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgGridColumns = 2'd0,
    CfgGridRows    = 2'd1,
    CfgPeriodicWrap = 2'd2,
    CfgStripMode   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DimWidth-1:0] grid_columns;
    logic [DimWidth-1:0] grid_rows;
    logic                periodic_wrap;
    logic                strip_mode;
  } cfg_t;

  typedef struct packed {
    logic [IndexWidth-1:0] vertex_index;
    logic                  is_restart;
    logic                  mesh_last;
  } res_t;

endpackage

/* src/gmig_pos.sv */
// Mesh position registers and index word generation.
// Depends on gmig_pkg.
`timescale 1ns / 1ps

module gmig_pos #(
  parameter int unsigned MAX_COLUMNS = gmig_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = gmig_pkg::DefMaxRows
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           restart_i,
  input  gmig_pkg::cfg_t cfg_i,
  output gmig_pkg::res_t res_o
);

  localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned RLW = $clog2(MAX_ROWS + 1);
  localparam longint unsigned MaxBase = longint'(MAX_ROWS) * longint'(MAX_COLUMNS);
  localparam int unsigned BW = $clog2(MaxBase);
  localparam int unsigned XW = gmig_pkg::IndexWidth;

  logic [CW-1:0] column_pos_q, column_pos_d, cpos;
  logic [RW-1:0] row_pos_q, row_pos_d, rpos;
  logic [2:0]    phase_pos_q, phase_pos_d, ph;
  logic [BW-1:0] row_base_q, row_base_d, rbase;

  logic [31:0]   gc32, gr32;
  logic [CW-1:0] cols;
  logic [RLW-1:0] rows;
  logic          last_row;
  logic [CW:0]   cpos1;
  logic [CW-1:0] left, right, strip_col, vcol, strip_end, list_end;
  logic          lower;
  logic [2:0]    lph;

  assign gc32 = 32'(cfg_i.grid_columns);
  assign gr32 = 32'(cfg_i.grid_rows);

  always_comb begin
    if (gc32 < 32'd2) begin
      cols = CW'(2);
    end else if (gc32 > 32'(MAX_COLUMNS)) begin
      cols = CW'(MAX_COLUMNS);
    end else begin
      cols = CW'(gc32);
    end
    if (gr32 < 32'd2) begin
      rows = RLW'(2);
    end else if (gr32 > 32'(MAX_ROWS)) begin
      rows = RLW'(MAX_ROWS);
    end else begin
      rows = RLW'(gr32);
    end
  end

  // drop the position on a restart request
  assign cpos  = restart_i ? '0 : column_pos_q;
  assign rpos  = restart_i ? '0 : row_pos_q;
  assign ph    = restart_i ? '0 : phase_pos_q;
  assign rbase = restart_i ? '0 : row_base_q;

  assign last_row  = RLW'(rpos) >= (rows - RLW'(2));
  assign cpos1     = {1'b0, cpos} + (CW + 1)'(1);
  assign left      = (cpos >= cols) ? (cols - CW'(1)) : cpos;
  assign right     = (cpos1 >= {1'b0, cols}) ? '0 : cpos1[CW-1:0];
  assign strip_col = (cpos >= cols) ? '0 : cpos;
  assign strip_end = cfg_i.periodic_wrap ? cols : (cols - CW'(1));
  assign list_end  = cfg_i.periodic_wrap ? (cols - CW'(1)) : (cols - CW'(2));
  assign lph       = (ph > 3'd5) ? 3'd5 : ph;

  always_comb begin
    res_o.is_restart = 1'b0;
    res_o.mesh_last  = 1'b0;
    column_pos_d     = cpos;
    row_pos_d        = rpos;
    phase_pos_d      = ph;
    row_base_d       = rbase;
    vcol             = strip_col;
    lower            = 1'b0;
    if (cfg_i.strip_mode) begin
      if (ph >= 3'd2) begin
        res_o.is_restart = 1'b1;
        if (last_row) begin
          res_o.mesh_last = 1'b1;
          column_pos_d    = '0;
          row_pos_d       = '0;
          phase_pos_d     = '0;
          row_base_d      = '0;
        end else begin
          row_pos_d    = rpos + RW'(1);
          row_base_d   = rbase + BW'(cols);
          column_pos_d = '0;
          phase_pos_d  = '0;
        end
      end else if (ph == 3'd0) begin
        phase_pos_d = 3'd1;
      end else begin
        lower = 1'b1;
        if (cpos >= strip_end) begin
          phase_pos_d = 3'd2;
        end else begin
          column_pos_d = cpos1[CW-1:0];
          phase_pos_d  = 3'd0;
        end
      end
    end else begin
      case (lph)
        3'd0: begin
          vcol = left;
        end
        3'd1: begin
          vcol  = left;
          lower = 1'b1;
        end
        3'd2, 3'd3: begin
          vcol = right;
        end
        3'd4: begin
          vcol  = left;
          lower = 1'b1;
        end
        default: begin
          vcol  = right;
          lower = 1'b1;
        end
      endcase
      if (lph < 3'd5) begin
        phase_pos_d = lph + 3'd1;
      end else if (cpos >= list_end) begin
        if (last_row) begin
          res_o.mesh_last = 1'b1;
          column_pos_d    = '0;
          row_pos_d       = '0;
          phase_pos_d     = '0;
          row_base_d      = '0;
        end else begin
          row_pos_d    = rpos + RW'(1);
          row_base_d   = rbase + BW'(cols);
          column_pos_d = '0;
          phase_pos_d  = '0;
        end
      end else begin
        column_pos_d = cpos1[CW-1:0];
        phase_pos_d  = 3'd0;
      end
    end
    if (res_o.is_restart) begin
      res_o.vertex_index = gmig_pkg::RestartWord;
    end else begin
      res_o.vertex_index = XW'(rbase) + XW'(vcol) + (lower ? XW'(cols) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_pos_q <= '0;
      row_pos_q    <= '0;
      phase_pos_q  <= '0;
      row_base_q   <= '0;
    end else if (adv_i) begin
      column_pos_q <= column_pos_d;
      row_pos_q    <= row_pos_d;
      phase_pos_q  <= phase_pos_d;
      row_base_q   <= row_base_d;
    end
  end

endmodule

/* src/grid_mesh_index_generator_top.sv */
// Top level of the grid mesh index generator: config registers, input and result registers.
// Depends on gmig_pkg and gmig_pos.
`timescale 1ns / 1ps

// Streams the triangle index buffer of a regular grid, one 32-bit index word per
// accepted input transaction, in list mode (six indices per quad) or strip mode
// (top/bottom pair per column, then a restart marker per row pair). Throughput is
// one word per clock while the output is not stalled: the input and result registers
// each hold one transaction and the next position is combinational, so an accepted
// transaction passes the input register, then the result register. The final word
// of the mesh carries mesh_last and the next transaction starts over.
// Write the configuration registers only while no transaction is in flight.
module grid_mesh_index_generator_top #(
  parameter int unsigned MAX_COLUMNS = gmig_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = gmig_pkg::DefMaxRows
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gmig_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [gmig_pkg::DimWidth-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                restart_mesh_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gmig_pkg::IndexWidth-1:0]     vertex_index_o,
  output logic                                is_restart_o,
  output logic                                mesh_last_o
);

  gmig_pkg::cfg_t cfg_q;
  gmig_pkg::res_t res, res_q;
  logic s1_valid_q, restart_q;
  logic out_valid_q;
  logic out_free, adv, in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_columns  <= gmig_pkg::DimWidth'(2);
      cfg_q.grid_rows     <= gmig_pkg::DimWidth'(2);
      cfg_q.periodic_wrap <= 1'b0;
      cfg_q.strip_mode    <= 1'b0;
    end else if (cfg_we_i) begin
      case (gmig_pkg::cfg_idx_e'(cfg_idx_i))
        gmig_pkg::CfgGridColumns:  cfg_q.grid_columns  <= cfg_data_i;
        gmig_pkg::CfgGridRows:     cfg_q.grid_rows     <= cfg_data_i;
        gmig_pkg::CfgPeriodicWrap: cfg_q.periodic_wrap <= cfg_data_i[0];
        gmig_pkg::CfgStripMode:    cfg_q.strip_mode    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      restart_q <= restart_mesh_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  gmig_pos #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .restart_i(restart_q),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = res_q.vertex_index;
  assign is_restart_o   = res_q.is_restart;
  assign mesh_last_o    = res_q.mesh_last;

endmodule

/* src/gmig_checker.sv */
// Port-level assertions for the grid mesh index generator, bound to its top level.
// Depends on gmig_pkg and grid_mesh_index_generator_top_assert.svh.
`timescale 1ns / 1ps
`include "grid_mesh_index_generator_top_assert.svh"

module gmig_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [gmig_pkg::IndexWidth-1:0]     vertex_index_o,
  input logic                                is_restart_o,
  input logic                                mesh_last_o
);

  `GMIG_ASSERT(a_marker_word,
    out_valid_o && is_restart_o |-> vertex_index_o == gmig_pkg::RestartWord,
    "restart marker without restart word")
  `GMIG_ASSERT(a_stall_cause,
    in_stall_o |-> out_valid_o && out_stall_i,
    "input stalled while output can move")
  `GMIG_ASSERT(a_latency,
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o,
    "accepted transaction did not reach the output")
  `GMIG_ASSERT_NEXT(a_out_hold,
    out_valid_o && out_stall_i,
    out_valid_o && $stable(vertex_index_o) && $stable(mesh_last_o),
    "stalled output changed")

endmodule

bind grid_mesh_index_generator_top gmig_checker u_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Testbench for grid_mesh_index_generator_top: streams advance transactions, walks the mesh
// in a local predictor and checks every index word in order. Depends on gmig_pkg and the RTL.

module testbench;

  localparam int unsigned MaxCols    = gmig_pkg::DefMaxColumns;
  localparam int unsigned MaxRows    = gmig_pkg::DefMaxRows;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct    = 21;

  logic                             clk          = 1'b0;
  logic                             rst_n        = 1'b0;
  logic                             cfg_we       = 1'b0;
  logic [gmig_pkg::CfgIdxWidth-1:0] cfg_idx      = gmig_pkg::CfgGridColumns;
  logic [gmig_pkg::DimWidth-1:0]    cfg_data     = '0;
  logic                             in_valid     = 1'b0;
  logic                             in_stall;
  logic                             restart_mesh = 1'b0;
  logic                             out_valid;
  logic                             out_stall    = 1'b0;
  logic [gmig_pkg::IndexWidth-1:0]  vertex_index;
  logic                             is_restart;
  logic                             mesh_last;

  int unsigned reg_cols  = 2;
  int unsigned reg_rows  = 2;
  bit          reg_wrap  = 1'b0;
  bit          reg_strip = 1'b0;

  int unsigned walk_col   = 0;
  int unsigned walk_row   = 0;
  int unsigned walk_phase = 0;
  int unsigned walk_base  = 0;

  bit              pending_restarts[$];
  gmig_pkg::res_t  expected_words[$];
  int unsigned     mismatches    = 0;
  int unsigned     words_checked = 0;
  int unsigned     cycle_count   = 0;
  int unsigned     holdoff_left  = 0;
  bit              holdoff_done  = 1'b0;
  bit              calm          = 1'b0;

  grid_mesh_index_generator_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .restart_mesh_i (restart_mesh),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .vertex_index_o (vertex_index),
    .is_restart_o   (is_restart),
    .mesh_last_o    (mesh_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic void clear_walk();
    walk_col   = 0;
    walk_row   = 0;
    walk_phase = 0;
    walk_base  = 0;
  endfunction

  function automatic void next_row_pair(int unsigned cols);
    walk_row++;
    walk_base  += cols;
    walk_col   = 0;
    walk_phase = 0;
  endfunction

  function automatic void queue_items(int unsigned n, bit restart);
    for (int unsigned i = 0; i < n; i++) begin
      pending_restarts.insert(pending_restarts.size(), restart);
    end
  endfunction

  function automatic int unsigned vertex_of(int unsigned cols, bit lower, int unsigned col);
    return walk_base + ((col >= cols) ? 0 : col) + (lower ? cols : 0);
  endfunction

  function automatic gmig_pkg::res_t next_index_word(bit restart);
    int unsigned    cols;
    int unsigned    rows;
    int unsigned    ncol;
    int unsigned    nquads;
    int unsigned    left;
    int unsigned    right;
    int unsigned    corner;
    bit             last_row;
    gmig_pkg::res_t word;
    cols = (reg_cols < 2) ? 2 : ((reg_cols > MaxCols) ? MaxCols : reg_cols);
    rows = (reg_rows < 2) ? 2 : ((reg_rows > MaxRows) ? MaxRows : reg_rows);
    word = '0;
    if (restart) clear_walk();
    last_row = walk_row >= rows - 2;
    if (reg_strip) begin
      ncol = reg_wrap ? cols + 1 : cols;
      if (walk_phase >= 2) begin
        word.vertex_index = gmig_pkg::RestartWord;
        word.is_restart   = 1'b1;
        if (last_row) begin
          word.mesh_last = 1'b1;
          clear_walk();
        end else begin
          next_row_pair(cols);
        end
      end else if (walk_phase == 0) begin
        word.vertex_index = vertex_of(cols, 1'b0, walk_col);
        walk_phase = 1;
      end else begin
        word.vertex_index = vertex_of(cols, 1'b1, walk_col);
        if (walk_col >= ncol - 1) begin
          walk_phase = 2;
        end else begin
          walk_col++;
          walk_phase = 0;
        end
      end
    end else begin
      nquads = reg_wrap ? cols : cols - 1;
      left   = (walk_col >= cols) ? cols - 1 : walk_col;
      right  = (walk_col + 1 >= cols) ? 0 : walk_col + 1;
      corner = (walk_phase > 5) ? 5 : walk_phase;
      case (corner)
        0:       word.vertex_index = vertex_of(cols, 1'b0, left);
        1:       word.vertex_index = vertex_of(cols, 1'b1, left);
        2, 3:    word.vertex_index = vertex_of(cols, 1'b0, right);
        4:       word.vertex_index = vertex_of(cols, 1'b1, left);
        default: word.vertex_index = vertex_of(cols, 1'b1, right);
      endcase
      if (corner < 5) begin
        walk_phase = corner + 1;
      end else if (walk_col >= nquads - 1) begin
        if (last_row) begin
          word.mesh_last = 1'b1;
          clear_walk();
        end else begin
          next_row_pair(cols);
        end
      end else begin
        walk_col++;
        walk_phase = 0;
      end
    end
    return word;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch on %s, word %0d: expected %0h, got %0h", what, words_checked, want,
               got);
    end
  endtask

  // Driver: hold a stalled transaction, otherwise offer the next pending one or idle at random.
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_words.insert(expected_words.size(), next_index_word(restart_mesh));
    end
    if (!(in_valid && in_stall)) begin
      if (pending_restarts.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        in_valid     <= 1'b1;
        restart_mesh <= pending_restarts.pop_front();
      end else begin
        in_valid     <= 1'b0;
        restart_mesh <= 1'($urandom_range(1));
      end
    end
  end

  // Monitor: check each accepted result against the oldest expected word.
  always @(posedge clk) begin : result_check
    gmig_pkg::res_t want;
    if (out_valid && !out_stall) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected transaction", '0, vertex_index);
      end else begin
        want = expected_words.pop_front();
        if (vertex_index !== want.vertex_index)
          report_mismatch("vertex_index", want.vertex_index, vertex_index);
        if (is_restart !== want.is_restart)
          report_mismatch("is_restart", 32'(want.is_restart), 32'(is_restart));
        if (mesh_last !== want.mesh_last)
          report_mismatch("mesh_last", 32'(want.mesh_last), 32'(mesh_last));
      end
    end
  end

  // Receiver: random idling plus one long hold-off.
  always @(posedge clk) begin : receiver
    if (holdoff_left != 0) begin
      holdoff_left--;
    end else if (!holdoff_done && words_checked >= 500 && pending_restarts.size() > 20) begin
      holdoff_left = 120;
      holdoff_done = 1'b1;
    end
    out_stall <= (holdoff_left != 0) || (!calm && $urandom_range(99) < IdlePct);
  end

  task automatic wait_idle();
    while (pending_restarts.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(gmig_pkg::cfg_idx_e idx, logic [gmig_pkg::DimWidth-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gmig_pkg::CfgGridColumns:  reg_cols  = 32'(value);
      gmig_pkg::CfgGridRows:     reg_rows  = 32'(value);
      gmig_pkg::CfgPeriodicWrap: reg_wrap  = value[0];
      gmig_pkg::CfgStripMode:    reg_strip = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [gmig_pkg::DimWidth-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return gmig_pkg::DimWidth'($urandom_range(8, 2));
    if (roll < 75) return gmig_pkg::DimWidth'($urandom_range(1, 0));
    if (roll < 85) return gmig_pkg::DimWidth'($urandom_range(8191, 4090));
    return gmig_pkg::DimWidth'($urandom_range(8191, 0));
  endfunction

  task automatic write_mode(bit wrap, bit strip);
    logic [gmig_pkg::DimWidth-1:0] noise;
    noise = gmig_pkg::DimWidth'($urandom_range(8191, 0));
    write_reg(gmig_pkg::CfgPeriodicWrap, {noise[gmig_pkg::DimWidth-1:1], wrap});
    noise = gmig_pkg::DimWidth'($urandom_range(8191, 0));
    write_reg(gmig_pkg::CfgStripMode, {noise[gmig_pkg::DimWidth-1:1], strip});
  endtask

  initial begin : stimulus
    int unsigned count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: one full list mesh, its wrap to the start, a restart mid-mesh.
    queue_items(7, 1'b0);
    queue_items(1, 1'b1);
    queue_items(2, 1'b0);
    wait_idle();

    // Switch to wrapped strip mid-mesh with clamped-low dimensions.
    write_reg(gmig_pkg::CfgGridColumns, 13'd0);
    write_reg(gmig_pkg::CfgGridRows, 13'd1);
    write_mode(1'b1, 1'b1);
    queue_items(8, 1'b0);
    wait_idle();

    // Clamped-high dimensions in list mode.
    write_reg(gmig_pkg::CfgGridColumns, 13'h1fff);
    write_reg(gmig_pkg::CfgGridRows, 13'h1fff);
    write_mode(1'b0, 1'b0);
    queue_items(1, 1'b1);
    queue_items(5, 1'b0);
    wait_idle();

    for (int phase = 0; phase < 30; phase++) begin
      case (phase)
        3: begin
          write_reg(gmig_pkg::CfgGridColumns, 13'd4096);
          write_reg(gmig_pkg::CfgGridRows, 13'd2);
          write_mode(1'b0, 1'b0);
        end
        7: begin
          write_reg(gmig_pkg::CfgGridColumns, 13'd2);
          write_reg(gmig_pkg::CfgGridRows, 13'd4096);
          write_mode(1'b1, 1'b1);
        end
        11: begin
          write_reg(gmig_pkg::CfgGridColumns, 13'd4096);
          write_reg(gmig_pkg::CfgGridRows, 13'd4096);
          write_mode(1'b1, 1'b0);
        end
        default: begin
          write_reg(gmig_pkg::CfgGridColumns, pick_dim());
          write_reg(gmig_pkg::CfgGridRows, pick_dim());
          write_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      endcase
      calm = (phase == 15);
      count = $urandom_range(80, 40);
      repeat (count) queue_items(1, $urandom_range(99) < 3);
      wait_idle();
      calm = 1'b0;
    end

    if (expected_words.size() != 0)
      report_mismatch("missing transactions", 32'(expected_words.size()), '0);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/gmig_pkg.sv
src/gmig_pos.sv
src/grid_mesh_index_generator_top.sv
src/gmig_checker.sv
bench/testbench.sv
